// ===== hw/rtl/ced_pkg.sv =====
package ced_pkg;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
    } t_out;

    // Escape progress, one-hot.
    typedef enum logic [32:0] {
        ST_IDLE = 33'b1 << 0,  ST_BSL = 33'b1 << 1,  ST_HEX0 = 33'b1 << 2,
        ST_HEX1 = 33'b1 << 3,  ST_SO  = 33'b1 << 4,  ST_N    = 33'b1 << 5,
        ST_NU   = 33'b1 << 6,  ST_NA  = 33'b1 << 7,  ST_S    = 33'b1 << 8,
        ST_ST   = 33'b1 << 9,  ST_SY  = 33'b1 << 10, ST_SU   = 33'b1 << 11,
        ST_E    = 33'b1 << 12, ST_ET  = 33'b1 << 13, ST_EO   = 33'b1 << 14,
        ST_EN   = 33'b1 << 15, ST_ES  = 33'b1 << 16, ST_A    = 33'b1 << 17,
        ST_AC   = 33'b1 << 18, ST_B   = 33'b1 << 19, ST_BE   = 33'b1 << 20,
        ST_C    = 33'b1 << 21, ST_CA  = 33'b1 << 22, ST_D    = 33'b1 << 23,
        ST_DL   = 33'b1 << 24, ST_DC  = 33'b1 << 25, ST_F    = 33'b1 << 26,
        ST_H    = 33'b1 << 27, ST_L   = 33'b1 << 28, ST_G    = 33'b1 << 29,
        ST_R    = 33'b1 << 30, ST_U   = 33'b1 << 31, ST_V    = 33'b1 << 32
    } t_state;

    localparam logic [7:0] C_BSLASH  = 8'h5C;
    localparam logic [7:0] C_LOWER_X = 8'h78;
    localparam logic [7:0] C_UPPER_H = 8'h48;
    localparam logic [7:0] C_SO_CODE = 8'h0E;
    localparam logic [7:0] C_SOH     = 8'h01;
    localparam logic [7:0] C_NUL     = 8'h00;

    // Decoded results of one item: count and up to two result items.
    typedef struct packed {
        logic [1:0] n;
        t_out       r0;
        t_out       r1;
    } t_dec;

    typedef struct packed {
        logic       hit;
        t_state     to;
        logic [7:0] code;
    } t_rule;

    // Bit 4 set means not a hex digit.
    function automatic logic [4:0] hexval(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= "0" && c <= "9") v = 5'(c - "0");
        else if (c >= "A" && c <= "F") v = 5'(c - "A" + 8'd10);
        else if (c >= "a" && c <= "f") v = 5'(c - "a" + 8'd10);
        return v;
    endfunction

    function automatic t_rule mk(input t_state to, input logic [7:0] code);
        t_rule r;
        r.hit  = 1'b1;
        r.to   = to;
        r.code = code;
        return r;
    endfunction

    // Mnemonic trie: next prefix, or completion (to idle) with its code.
    function automatic t_rule rule_lookup(input t_state s, input logic [7:0] c);
        t_rule r;
        r.hit  = 1'b0;
        r.to   = ST_IDLE;
        r.code = 8'h00;
        unique case (s)
            ST_BSL: begin
                case (c)
                    "N": r = mk(ST_N, 8'h00);
                    "S": r = mk(ST_S, 8'h00);
                    "E": r = mk(ST_E, 8'h00);
                    "A": r = mk(ST_A, 8'h00);
                    "B": r = mk(ST_B, 8'h00);
                    "C": r = mk(ST_C, 8'h00);
                    "D": r = mk(ST_D, 8'h00);
                    "F": r = mk(ST_F, 8'h00);
                    "H": r = mk(ST_H, 8'h00);
                    "L": r = mk(ST_L, 8'h00);
                    "G": r = mk(ST_G, 8'h00);
                    "R": r = mk(ST_R, 8'h00);
                    "U": r = mk(ST_U, 8'h00);
                    "V": r = mk(ST_V, 8'h00);
                    default: ;
                endcase
            end
            ST_N: begin
                case (c)
                    "U": r = mk(ST_NU, 8'h00);
                    "A": r = mk(ST_NA, 8'h00);
                    default: ;
                endcase
            end
            ST_NU: if (c == "L") r = mk(ST_IDLE, 8'h00);
            ST_NA: if (c == "K") r = mk(ST_IDLE, 8'h15);
            ST_S: begin
                case (c)
                    "O": r = mk(ST_SO, 8'h00);
                    "T": r = mk(ST_ST, 8'h00);
                    "I": r = mk(ST_IDLE, 8'h0F);
                    "Y": r = mk(ST_SY, 8'h00);
                    "U": r = mk(ST_SU, 8'h00);
                    default: ;
                endcase
            end
            ST_ST: if (c == "X") r = mk(ST_IDLE, 8'h02);
            ST_SY: if (c == "N") r = mk(ST_IDLE, 8'h16);
            ST_SU: if (c == "B") r = mk(ST_IDLE, 8'h1A);
            ST_E: begin
                case (c)
                    "T": r = mk(ST_ET, 8'h00);
                    "O": r = mk(ST_EO, 8'h00);
                    "N": r = mk(ST_EN, 8'h00);
                    "M": r = mk(ST_IDLE, 8'h19);
                    "S": r = mk(ST_ES, 8'h00);
                    default: ;
                endcase
            end
            ST_ET: begin
                case (c)
                    "X": r = mk(ST_IDLE, 8'h03);
                    "B": r = mk(ST_IDLE, 8'h17);
                    default: ;
                endcase
            end
            ST_EO: if (c == "T") r = mk(ST_IDLE, 8'h04);
            ST_EN: if (c == "Q") r = mk(ST_IDLE, 8'h05);
            ST_ES: if (c == "C") r = mk(ST_IDLE, 8'h1B);
            ST_A:  if (c == "C") r = mk(ST_AC, 8'h00);
            ST_AC: if (c == "K") r = mk(ST_IDLE, 8'h06);
            ST_B: begin
                case (c)
                    "E": r = mk(ST_BE, 8'h00);
                    "S": r = mk(ST_IDLE, 8'h08);
                    default: ;
                endcase
            end
            ST_BE: if (c == "L") r = mk(ST_IDLE, 8'h07);
            ST_C: begin
                case (c)
                    "R": r = mk(ST_IDLE, 8'h0D);
                    "A": r = mk(ST_CA, 8'h00);
                    default: ;
                endcase
            end
            ST_CA: if (c == "N") r = mk(ST_IDLE, 8'h18);
            ST_D: begin
                case (c)
                    "L": r = mk(ST_DL, 8'h00);
                    "C": r = mk(ST_DC, 8'h00);
                    default: ;
                endcase
            end
            ST_DL: if (c == "E") r = mk(ST_IDLE, 8'h10);
            ST_DC: begin
                case (c)
                    "1": r = mk(ST_IDLE, 8'h11);
                    "2": r = mk(ST_IDLE, 8'h12);
                    "3": r = mk(ST_IDLE, 8'h13);
                    "4": r = mk(ST_IDLE, 8'h14);
                    default: ;
                endcase
            end
            ST_F: begin
                case (c)
                    "F": r = mk(ST_IDLE, 8'h0C);
                    "S": r = mk(ST_IDLE, 8'h1C);
                    default: ;
                endcase
            end
            ST_H: if (c == "T") r = mk(ST_IDLE, 8'h09);
            ST_L: if (c == "F") r = mk(ST_IDLE, 8'h0A);
            ST_G: if (c == "S") r = mk(ST_IDLE, 8'h1D);
            ST_R: if (c == "S") r = mk(ST_IDLE, 8'h1E);
            ST_U: if (c == "S") r = mk(ST_IDLE, 8'h1F);
            ST_V: if (c == "T") r = mk(ST_IDLE, 8'h0B);
            default: ;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/control_mnemonic_escape_decoder.sv =====
// A result item is written into the output queue when its input item is accepted, and is offered from there.
// Throughput: one input item per cycle while each gives at most one result;
// an item that gives two results offers them one after the other, and intake stalls
// when more than two results wait in the four-entry output queue.
// Reset (synchronous, active low): escape prefix back to idle, held hex digit
// cleared, output queue emptied.
module control_mnemonic_escape_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ced_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output ced_pkg::t_out o_data
);

    // Escape progress and the first character seen after \x.
    ced_pkg::t_state r_state;
    logic [7:0]      r_held;
    ced_pkg::t_state n_state;
    logic [7:0]      n_held;
    ced_pkg::t_dec   dec;
    logic            accept;
    logic            full;

    // Take an item whenever the queue has room for two results.
    assign o_stall = full;
    assign accept  = i_valid && !full;

    // Decode one character against the pending prefix, flush on end of string.
    ced_step u_step (
        .i_state (r_state),
        .i_held  (r_held),
        .i_item  (i_data),
        .o_state (n_state),
        .o_held  (n_held),
        .o_dec   (dec)
    );

    // Advance the prefix only on an accepted item; hold it otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ced_pkg::ST_IDLE;
            r_held  <= 8'h00;
        end else if (accept) begin
            r_state <= n_state;
            r_held  <= n_held;
        end
    end

    // Result queue parts the intake from the consumer's stall.
    ced_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_dec   (dec),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

// ===== hw/rtl/ced_step.sv =====
module ced_step (
    input  ced_pkg::t_state i_state,
    input  logic [7:0]      i_held,
    input  ced_pkg::t_in    i_item,
    output ced_pkg::t_state o_state,
    output logic [7:0]      o_held,
    output ced_pkg::t_dec   o_dec
);

    ced_pkg::t_state ns;
    ced_pkg::t_rule  rule;
    logic [1:0]      pn;
    logic [7:0]      pb0;
    logic [7:0]      pb1;
    logic            fv;
    logic [7:0]      fb;
    logic [4:0]      hi;
    logic [4:0]      lo;
    logic [4:0]      hf;
    logic [7:0]      c;
    logic            last;
    logic [7:0]      nh;
    logic [1:0]      n;

    always_comb begin
        c    = i_item.in_char;
        last = i_item.in_last;
        ns   = i_state;
        nh   = i_held;
        pn   = 2'd0;
        pb0  = c;
        pb1  = c;
        rule = ced_pkg::rule_lookup(i_state, c);
        hi   = ced_pkg::hexval(i_held);
        lo   = ced_pkg::hexval(c);

        unique case (i_state)
            ced_pkg::ST_IDLE: begin
                if (c == ced_pkg::C_BSLASH) begin
                    ns = ced_pkg::ST_BSL;
                end else begin
                    pn = 2'd1;
                end
            end
            ced_pkg::ST_HEX0: begin
                nh = c;
                ns = ced_pkg::ST_HEX1;
            end
            ced_pkg::ST_HEX1: begin
                pn  = 2'd1;
                pb0 = (!hi[4] && !lo[4]) ? {hi[3:0], lo[3:0]} : ced_pkg::C_NUL;
                ns  = ced_pkg::ST_IDLE;
            end
            ced_pkg::ST_SO: begin
                // Shift-out resolves, then a non-H character starts over from idle.
                pn = 2'd1;
                ns = ced_pkg::ST_IDLE;
                if (c == ced_pkg::C_UPPER_H) begin
                    pb0 = ced_pkg::C_SOH;
                end else begin
                    pb0 = ced_pkg::C_SO_CODE;
                    if (c == ced_pkg::C_BSLASH) begin
                        ns = ced_pkg::ST_BSL;
                    end else begin
                        pn = 2'd2;
                    end
                end
            end
            ced_pkg::ST_BSL: begin
                if (c == ced_pkg::C_LOWER_X) begin
                    ns = ced_pkg::ST_HEX0;
                end else if (c == ced_pkg::C_BSLASH) begin
                    pn  = 2'd1;
                    pb0 = ced_pkg::C_BSLASH;
                    ns  = ced_pkg::ST_IDLE;
                end else if (rule.hit) begin
                    ns = rule.to;
                end else begin
                    pn  = 2'd2;
                    pb0 = ced_pkg::C_BSLASH;
                    ns  = ced_pkg::ST_IDLE;
                end
            end
            default: begin
                if (!rule.hit) begin
                    pn = 2'd1;
                    ns = ced_pkg::ST_IDLE;
                end else if (rule.to == ced_pkg::ST_IDLE) begin
                    pn  = 2'd1;
                    pb0 = rule.code;
                    ns  = ced_pkg::ST_IDLE;
                end else begin
                    ns = rule.to;
                end
            end
        endcase

        // End-of-string flush of whatever prefix is left.
        hf = ced_pkg::hexval(nh);
        fv = 1'b0;
        fb = ced_pkg::C_NUL;
        if (last) begin
            unique case (ns)
                ced_pkg::ST_BSL: begin
                    fv = 1'b1;
                    fb = ced_pkg::C_BSLASH;
                end
                ced_pkg::ST_SO: begin
                    fv = 1'b1;
                    fb = ced_pkg::C_SO_CODE;
                end
                ced_pkg::ST_HEX0: begin
                    fv = 1'b1;
                end
                ced_pkg::ST_HEX1: begin
                    fv = 1'b1;
                    fb = hf[4] ? ced_pkg::C_NUL : {4'h0, hf[3:0]};
                end
                default: ;
            endcase
            ns = ced_pkg::ST_IDLE;
            nh = 8'h00;
        end

        n = (fv && pn != 2'd2) ? pn + 2'd1 : pn;

        o_dec.r0.out_byte   = (pn != 2'd0) ? pb0 : fb;
        o_dec.r0.byte_valid = 1'b1;
        o_dec.r1.out_byte   = (pn == 2'd2) ? pb1 : fb;
        o_dec.r1.byte_valid = 1'b1;
        if (last && n == 2'd0) begin
            // Bare end marker.
            n                   = 2'd1;
            o_dec.r0.out_byte   = 8'h00;
            o_dec.r0.byte_valid = 1'b0;
        end
        o_dec.r0.out_last = last && (n == 2'd1);
        o_dec.r1.out_last = last && (n == 2'd2);
        o_dec.n           = n;

        o_state = ns;
        o_held  = nh;
    end

endmodule

// ===== hw/rtl/ced_outq.sv =====
module ced_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ced_pkg::t_dec i_dec,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_stall,
    output ced_pkg::t_out o_data
);

    ced_pkg::t_out r_mem [4];
    logic [1:0]    r_wp;
    logic [1:0]    r_rp;
    logic [2:0]    r_cnt;
    logic [1:0]    push_n;
    logic          pop;

    assign push_n  = i_push ? i_dec.n : 2'd0;
    assign o_valid = (r_cnt != 3'd0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rp];
    // Room for a full two-result item is kept whenever intake is open.
    assign o_full  = (r_cnt > 3'd2);

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wp] <= i_dec.r0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_dec.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= r_wp + push_n;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, push_n} - {2'b00, pop};
        end
    end

endmodule

// ===== hw/rtl/ced_check.sv =====
module ced_check (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input ced_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_stall,
    input ced_pkg::t_out o_data
);

    // Queue empties on reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    // A bare end marker only ever closes a string.
    a_bare_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.byte_valid |-> o_data.out_last)
        else $error("bare end marker without last");

    // Intake only stalls when results are waiting.
    a_stall_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("intake stalled with empty queue");

    // No result appears without an accepted item.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !(i_valid && !o_stall) |=> !o_valid)
        else $error("result without an item");

    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

endmodule

bind control_mnemonic_escape_decoder ced_check u_ced_check (.*);
